[hw/rtl/fjd_pkg.sv]
// ----------------------------------------------------------------------------
// fjd_pkg
// Shared types, widths and codes of the FIFO job dispatcher.
// ----------------------------------------------------------------------------
package fjd_pkg;

	localparam int NUM_WORKERS_DEF = 8;
	localparam int QUEUE_DEPTH_DEF = 16;

	localparam int ID_W     = 16;
	localparam int LINES_W  = 16;
	localparam int STATUS_W = 2;

	localparam logic OP_ENQUEUE = 1'b0;
	localparam logic OP_TICK    = 1'b1;

	localparam logic [STATUS_W-1:0] ST_PRINTED  = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FINISHED = 2'd1;
	localparam logic [STATUS_W-1:0] ST_REJECTED = 2'd2;

	typedef struct packed {
		logic empty;
		logic full;
	} queue_stat_t;

endpackage

[hw/rtl/fifo_job_dispatcher.sv]
// ----------------------------------------------------------------------------
// fifo_job_dispatcher
// Job FIFO feeding a row of workers, one worker visited per cycle on a tick.
// ----------------------------------------------------------------------------
// Usage: drive opcode, job_id and job_lines with start; the request is taken
// at an edge where start is high and busy is low.
// Enqueue: busy stays low. A job that finds the queue full or has zero lines
// is dropped and one rejected result follows in the next cycle.
// Tick: busy rises. A prime state primes the worker and queue memory reads,
// then a sweep state visits each worker and runs the shared decrement and
// zero compare: a free worker takes the queue head, a busy one prints a line.
// Each result leaves through a one-entry hold register so the final one can
// carry last; a drain state releases it. The worker sweep sets the rate.
// Results appear on result_valid for one cycle each; the receiver cannot
// stall them. A tick with no busy worker and an empty queue gives no result.
// Reset empties the queue and frees all workers; queue and worker payload
// memories are not cleared and their contents are only used once written.
// ----------------------------------------------------------------------------
module fifo_job_dispatcher #(
	parameter int NUM_WORKERS = fjd_pkg::NUM_WORKERS_DEF,
	parameter int QUEUE_DEPTH = fjd_pkg::QUEUE_DEPTH_DEF,
	localparam int IDX_W = (NUM_WORKERS > 1) ? $clog2(NUM_WORKERS) : 1
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic                        opcode,
	input  logic [fjd_pkg::ID_W-1:0]     job_id,
	input  logic [fjd_pkg::LINES_W-1:0]  job_lines,
	output logic                        result_valid,
	output logic [IDX_W-1:0]            worker_index,
	output logic [fjd_pkg::ID_W-1:0]     job_id_out,
	output logic [fjd_pkg::LINES_W-1:0]  lines_left,
	output logic [fjd_pkg::STATUS_W-1:0] status,
	output logic                        last
);

	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(NUM_WORKERS - 1);

	typedef enum logic [1:0] {
		S_IDLE,
		S_PRIME,
		S_SWEEP,
		S_DRAIN
	} state_t;

	state_t state_q;
	logic [IDX_W-1:0] widx_q;

	logic                        pend_valid_q;
	logic [IDX_W-1:0]            pend_idx_q;
	logic [fjd_pkg::ID_W-1:0]     pend_id_q;
	logic [fjd_pkg::LINES_W-1:0]  pend_lines_q;
	logic [fjd_pkg::STATUS_W-1:0] pend_status_q;

	logic                        q_push;
	logic                        q_pop;
	logic [fjd_pkg::ID_W-1:0]     q_head_id;
	logic [fjd_pkg::LINES_W-1:0]  q_head_lines;
	fjd_pkg::queue_stat_t        q_stat;

	logic [IDX_W-1:0]            w_rd_idx;
	logic [fjd_pkg::ID_W-1:0]     w_id;
	logic [fjd_pkg::LINES_W-1:0]  w_lines;
	logic                        w_busy;

	logic                        accept;
	logic                        reject;
	logic                        take;
	logic                        active;
	logic [fjd_pkg::ID_W-1:0]     cur_id;
	logic [fjd_pkg::LINES_W-1:0]  cur_lines;
	logic [fjd_pkg::LINES_W-1:0]  left;
	logic                        done;

	assign busy   = (state_q != S_IDLE);
	assign accept = start && !busy;
	assign reject = accept && (opcode == fjd_pkg::OP_ENQUEUE)
		&& (q_stat.full || (job_lines == '0));
	assign q_push = accept && (opcode == fjd_pkg::OP_ENQUEUE) && !reject;

	// a free worker takes the head job, then every active worker prints a line
	assign take      = (state_q == S_SWEEP) && !w_busy && !q_stat.empty;
	assign active    = (state_q == S_SWEEP) && (w_busy || take);
	assign q_pop     = take;
	assign cur_id    = w_busy ? w_id : q_head_id;
	assign cur_lines = w_busy ? w_lines : q_head_lines;
	assign left      = cur_lines - 1'b1;
	assign done      = (left == '0);

	// prefetch the next worker's entry while the current one is worked on
	assign w_rd_idx = ((state_q == S_SWEEP) && (widx_q != IDX_LAST)) ? widx_q + 1'b1 : '0;

	fjd_queue #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_id    (job_id),
		.push_lines (job_lines),
		.pop        (q_pop),
		.head_id    (q_head_id),
		.head_lines (q_head_lines),
		.stat       (q_stat)
	);

	fjd_workers #(
		.NUM_WORKERS (NUM_WORKERS)
	) u_workers (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_idx   (w_rd_idx),
		.rd_id    (w_id),
		.rd_lines (w_lines),
		.cur_idx  (widx_q),
		.cur_busy (w_busy),
		.wr_en    (active),
		.wr_id    (cur_id),
		.wr_lines (left),
		.wr_busy  (!done)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			widx_q        <= '0;
			pend_valid_q  <= 1'b0;
			pend_idx_q    <= '0;
			pend_id_q     <= '0;
			pend_lines_q  <= '0;
			pend_status_q <= fjd_pkg::ST_PRINTED;
			result_valid  <= 1'b0;
			worker_index  <= '0;
			job_id_out    <= '0;
			lines_left    <= '0;
			status        <= fjd_pkg::ST_PRINTED;
			last          <= 1'b0;
		end else begin
			result_valid <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (reject) begin
						result_valid <= 1'b1;
						worker_index <= '0;
						job_id_out   <= job_id;
						lines_left   <= job_lines;
						status       <= fjd_pkg::ST_REJECTED;
						last         <= 1'b1;
					end else if (accept && (opcode == fjd_pkg::OP_TICK)) begin
						widx_q  <= '0;
						state_q <= S_PRIME;
					end
				end
				S_PRIME: begin
					state_q <= S_SWEEP;
				end
				S_SWEEP: begin
					if (active) begin
						// release the held result, hold the new one
						if (pend_valid_q) begin
							result_valid <= 1'b1;
							worker_index <= pend_idx_q;
							job_id_out   <= pend_id_q;
							lines_left   <= pend_lines_q;
							status       <= pend_status_q;
							last         <= 1'b0;
						end
						pend_valid_q  <= 1'b1;
						pend_idx_q    <= widx_q;
						pend_id_q     <= cur_id;
						pend_lines_q  <= left;
						pend_status_q <= done ? fjd_pkg::ST_FINISHED : fjd_pkg::ST_PRINTED;
					end
					if (widx_q == IDX_LAST) begin
						state_q <= S_DRAIN;
					end else begin
						widx_q <= widx_q + 1'b1;
					end
				end
				S_DRAIN: begin
					if (pend_valid_q) begin
						result_valid <= 1'b1;
						worker_index <= pend_idx_q;
						job_id_out   <= pend_id_q;
						lines_left   <= pend_lines_q;
						status       <= pend_status_q;
						last         <= 1'b1;
					end
					pend_valid_q <= 1'b0;
					state_q      <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTH
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_stat.empty)
		else $error("queue popped while empty");

	a_hold_clear_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !pend_valid_q)
		else $error("held result left over after tick");

	a_busy_has_lines: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_SWEEP) && w_busy) |-> (w_lines != '0))
		else $error("busy worker with no lines");

	a_reject_last: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && (status == fjd_pkg::ST_REJECTED)) |-> (last && !busy))
		else $error("rejected request result malformed");
`endif

endmodule

[hw/rtl/fjd_queue.sv]
// ----------------------------------------------------------------------------
// fjd_queue
// Job FIFO: id and line count memory with head, tail and fill count.
// ----------------------------------------------------------------------------
module fjd_queue #(
	parameter int QUEUE_DEPTH = fjd_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  logic [fjd_pkg::ID_W-1:0]    push_id,
	input  logic [fjd_pkg::LINES_W-1:0] push_lines,
	input  logic                       pop,
	output logic [fjd_pkg::ID_W-1:0]    head_id,
	output logic [fjd_pkg::LINES_W-1:0] head_lines,
	output fjd_pkg::queue_stat_t        stat
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

	logic [fjd_pkg::ID_W-1:0]    id_mem    [QUEUE_DEPTH];
	logic [fjd_pkg::LINES_W-1:0] lines_mem [QUEUE_DEPTH];

	logic [PTR_W-1:0] head_q;
	logic [PTR_W-1:0] tail_q;
	logic [CNT_W-1:0] count_q;
	logic [PTR_W-1:0] head_inc;
	logic [PTR_W-1:0] tail_inc;
	logic [PTR_W-1:0] rd_addr;

	assign head_inc = (head_q == PTR_LAST) ? '0 : head_q + 1'b1;
	assign tail_inc = (tail_q == PTR_LAST) ? '0 : tail_q + 1'b1;

	// prefetch the entry behind the head when the head is taken this cycle
	assign rd_addr = pop ? head_inc : head_q;

	assign stat.empty = (count_q == '0);
	assign stat.full  = (count_q == CNT_FULL);

	always_ff @(posedge clk) begin
		if (push) begin
			id_mem[tail_q]    <= push_id;
			lines_mem[tail_q] <= push_lines;
		end
		head_id    <= id_mem[rd_addr];
		head_lines <= lines_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				tail_q <= tail_inc;
			end
			if (pop) begin
				head_q <= head_inc;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

[hw/rtl/fjd_workers.sv]
// ----------------------------------------------------------------------------
// fjd_workers
// Worker row: busy flags plus a job id and line count memory per worker.
// ----------------------------------------------------------------------------
module fjd_workers #(
	parameter int NUM_WORKERS = fjd_pkg::NUM_WORKERS_DEF,
	localparam int IDX_W = (NUM_WORKERS > 1) ? $clog2(NUM_WORKERS) : 1
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [IDX_W-1:0]           rd_idx,
	output logic [fjd_pkg::ID_W-1:0]    rd_id,
	output logic [fjd_pkg::LINES_W-1:0] rd_lines,
	input  logic [IDX_W-1:0]           cur_idx,
	output logic                       cur_busy,
	input  logic                       wr_en,
	input  logic [fjd_pkg::ID_W-1:0]    wr_id,
	input  logic [fjd_pkg::LINES_W-1:0] wr_lines,
	input  logic                       wr_busy
);

	logic [fjd_pkg::ID_W-1:0]    id_mem    [NUM_WORKERS];
	logic [fjd_pkg::LINES_W-1:0] lines_mem [NUM_WORKERS];
	logic [NUM_WORKERS-1:0]      busy_q;

	assign cur_busy = busy_q[cur_idx];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			id_mem[cur_idx]    <= wr_id;
			lines_mem[cur_idx] <= wr_lines;
		end
		rd_id    <= id_mem[rd_idx];
		rd_lines <= lines_mem[rd_idx];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= '0;
		end else if (wr_en) begin
			busy_q[cur_idx] <= wr_busy;
		end
	end

endmodule

[verif/fifo_job_dispatcher_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fifo_job_dispatcher_tb
// Self-checking bench for the job FIFO and its row of workers.
// A short table of directed requests comes first: idle tick, zero-line and
// queue-full rejects, and the extreme id and line values. A random mix of
// enqueue bursts and ticks follows. Every accepted request runs through a
// local dispatch model, and each strobed result is checked in order.
// ----------------------------------------------------------------------------
module fifo_job_dispatcher_tb;

	localparam int NW    = fjd_pkg::NUM_WORKERS_DEF;
	localparam int QD    = fjd_pkg::QUEUE_DEPTH_DEF;
	localparam int IDX_W = $clog2(NW);
	localparam int LIMIT = 200000;

	typedef struct packed {
		logic [IDX_W-1:0]             widx;
		logic [fjd_pkg::ID_W-1:0]     id;
		logic [fjd_pkg::LINES_W-1:0]  left;
		logic [fjd_pkg::STATUS_W-1:0] st;
		logic                         lst;
	} report_t;

	typedef struct packed {
		logic                        op;
		logic [fjd_pkg::ID_W-1:0]    id;
		logic [fjd_pkg::LINES_W-1:0] lines;
		logic [4:0]                  reps;
		logic                        typed;
		report_t                     want;
	} plan_row_t;

	logic                         clk = 1'b0;
	logic                         arst_n = 1'b0;
	logic                         start = 1'b0;
	logic                         opcode = fjd_pkg::OP_ENQUEUE;
	logic [fjd_pkg::ID_W-1:0]     job_id = '0;
	logic [fjd_pkg::LINES_W-1:0]  job_lines = '0;
	logic                         busy;
	logic                         result_valid;
	logic [IDX_W-1:0]             worker_index;
	logic [fjd_pkg::ID_W-1:0]     job_id_out;
	logic [fjd_pkg::LINES_W-1:0]  lines_left;
	logic [fjd_pkg::STATUS_W-1:0] status;
	logic                         last;

	// dispatch model state
	logic [fjd_pkg::ID_W-1:0]    mq_id [QD];
	logic [fjd_pkg::LINES_W-1:0] mq_lines [QD];
	int                          mq_head = 0;
	int                          mq_count = 0;
	logic                        wk_busy [NW];
	logic [fjd_pkg::ID_W-1:0]    wk_id [NW];
	logic [fjd_pkg::LINES_W-1:0] wk_lines [NW];

	report_t   step_reports[$];
	report_t   due_reports[$];
	plan_row_t plan[$];
	report_t   seen_want;
	int        mismatch_count = 0;
	int        cycle_count = 0;

	fifo_job_dispatcher uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.opcode       (opcode),
		.job_id       (job_id),
		.job_lines    (job_lines),
		.result_valid (result_valid),
		.worker_index (worker_index),
		.job_id_out   (job_id_out),
		.lines_left   (lines_left),
		.status       (status),
		.last         (last)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic note_mismatch(input string msg);
		mismatch_count++;
		$display("mismatch @%0d: %s", cycle_count, msg);
	endtask

	function automatic logic [15:0] pick16(input int unsigned lo, input int unsigned hi);
		logic [31:0] v;
		v = $urandom_range(hi, lo);
		return v[15:0];
	endfunction

	// Work out the reports one request causes and advance the model.
	task automatic dispatch_step(input logic op, input logic [fjd_pkg::ID_W-1:0] id,
			input logic [fjd_pkg::LINES_W-1:0] ln);
		report_t r;
		int      w;
		int      tail;
		step_reports.delete();
		if (op == fjd_pkg::OP_ENQUEUE) begin
			if (mq_count >= QD || ln == '0) begin
				r.widx = '0;
				r.id   = id;
				r.left = ln;
				r.st   = fjd_pkg::ST_REJECTED;
				r.lst  = 1'b1;
				step_reports.push_back(r);
			end else begin
				tail = (mq_head + mq_count) % QD;
				mq_id[tail]    = id;
				mq_lines[tail] = ln;
				mq_count++;
			end
		end else begin
			// hand out queued jobs to free workers, lowest index first
			for (w = 0; w < NW && mq_count > 0; w++) begin
				if (!wk_busy[w]) begin
					wk_id[w]    = mq_id[mq_head];
					wk_lines[w] = mq_lines[mq_head];
					wk_busy[w]  = 1'b1;
					mq_head     = (mq_head + 1) % QD;
					mq_count--;
				end
			end
			for (w = 0; w < NW; w++) begin
				if (wk_busy[w]) begin
					wk_lines[w] = wk_lines[w] - 16'd1;
					r.widx = w[IDX_W-1:0];
					r.id   = wk_id[w];
					r.left = wk_lines[w];
					r.st   = (wk_lines[w] == '0) ? fjd_pkg::ST_FINISHED : fjd_pkg::ST_PRINTED;
					r.lst  = 1'b0;
					if (wk_lines[w] == '0)
						wk_busy[w] = 1'b0;
					step_reports.push_back(r);
				end
			end
			if (step_reports.size() > 0)
				step_reports[step_reports.size() - 1].lst = 1'b1;
		end
	endtask

	// Present one request and hold it until taken; returns at the accepting edge.
	task automatic issue(input logic op, input logic [fjd_pkg::ID_W-1:0] id,
			input logic [fjd_pkg::LINES_W-1:0] ln, input logic typed, input report_t want);
		start     <= 1'b1;
		opcode    <= op;
		job_id    <= id;
		job_lines <= ln;
		do @(posedge clk); while (busy);
		dispatch_step(op, id, ln);
		if (typed)
			due_reports.push_back(want);
		else
			foreach (step_reports[k])
				due_reports.push_back(step_reports[k]);
	endtask

	task automatic maybe_pause(input logic quiet);
		int gap;
		if (!quiet && $urandom_range(99, 0) < 20) begin
			gap = $urandom_range(6, 1);
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic add_row(input logic op, input logic [fjd_pkg::ID_W-1:0] id,
			input logic [fjd_pkg::LINES_W-1:0] ln, input logic [4:0] reps,
			input logic typed, input report_t want);
		plan_row_t p;
		p.op    = op;
		p.id    = id;
		p.lines = ln;
		p.reps  = reps;
		p.typed = typed;
		p.want  = want;
		plan.push_back(p);
	endtask

	initial begin
		int                          i;
		int                          r;
		int                          pick;
		int                          enq_pct;
		logic                        op;
		logic [fjd_pkg::ID_W-1:0]    cur_id;
		logic [fjd_pkg::LINES_W-1:0] ln;
		for (i = 0; i < NW; i++) begin
			wk_busy[i]  = 1'b0;
			wk_id[i]    = '0;
			wk_lines[i] = '0;
		end
		for (i = 0; i < QD; i++) begin
			mq_id[i]    = '0;
			mq_lines[i] = '0;
		end

		//       op                   id        lines     reps  typed  expected report
		add_row(fjd_pkg::OP_TICK,    16'h0000, 16'h0000, 5'd1, 1'b0, '0);
		add_row(fjd_pkg::OP_ENQUEUE, 16'hFFFF, 16'h0000, 5'd1, 1'b1,
			report_t'{3'd0, 16'hFFFF, 16'h0000, fjd_pkg::ST_REJECTED, 1'b1});
		add_row(fjd_pkg::OP_ENQUEUE, 16'h0000, 16'h0001, 5'd1, 1'b0, '0);
		add_row(fjd_pkg::OP_TICK,    16'h0000, 16'h0000, 5'd1, 1'b1,
			report_t'{3'd0, 16'h0000, 16'h0000, fjd_pkg::ST_FINISHED, 1'b1});
		add_row(fjd_pkg::OP_ENQUEUE, 16'hFFFF, 16'hFFFF, 5'd1, 1'b0, '0);
		add_row(fjd_pkg::OP_TICK,    16'hFFFF, 16'hFFFF, 5'd1, 1'b1,
			report_t'{3'd0, 16'hFFFF, 16'hFFFE, fjd_pkg::ST_PRINTED, 1'b1});
		add_row(fjd_pkg::OP_ENQUEUE, 16'h1000, 16'h0002, 5'd16, 1'b0, '0);
		add_row(fjd_pkg::OP_ENQUEUE, 16'hABCD, 16'h1234, 5'd1, 1'b1,
			report_t'{3'd0, 16'hABCD, 16'h1234, fjd_pkg::ST_REJECTED, 1'b1});
		add_row(fjd_pkg::OP_ENQUEUE, 16'h5555, 16'h0000, 5'd1, 1'b1,
			report_t'{3'd0, 16'h5555, 16'h0000, fjd_pkg::ST_REJECTED, 1'b1});
		add_row(fjd_pkg::OP_TICK,    16'h0000, 16'h0000, 5'd2, 1'b0, '0);

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		foreach (plan[n]) begin
			cur_id = plan[n].id;
			for (r = 0; r < plan[n].reps; r++) begin
				issue(plan[n].op, cur_id, plan[n].lines, plan[n].typed, plan[n].want);
				cur_id = cur_id + 16'd1;
				maybe_pause(1'b0);
			end
		end

		enq_pct = 50;
		for (i = 0; i < 345; i++) begin
			// every 40 requests, pick balanced traffic or enqueue bursts that fill the queue
			if (i % 40 == 0)
				enq_pct = ($urandom_range(1, 0) != 0) ? 92 : 45;
			op     = ($urandom_range(99, 0) < enq_pct) ? fjd_pkg::OP_ENQUEUE
				: fjd_pkg::OP_TICK;
			cur_id = pick16(0, 16'hFFFF);
			pick   = $urandom_range(99, 0);
			if (mq_count >= QD)
				ln = pick16(0, 16'hFFFF);
			else if (pick < 5)
				ln = '0;
			else if (pick < 75)
				ln = pick16(1, 4);
			else
				ln = pick16(5, 40);
			issue(op, cur_id, ln, 1'b0, '0);
			maybe_pause(i >= 120 && i < 220);
		end
		start <= 1'b0;

		while (due_reports.size() != 0)
			@(posedge clk);
		repeat (NW + 4) @(posedge clk);
		if (mismatch_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n && result_valid) begin
			if (due_reports.size() == 0) begin
				note_mismatch($sformatf("unexpected report worker %0d job %h left %h status %0d",
					worker_index, job_id_out, lines_left, status));
			end else begin
				seen_want = due_reports.pop_front();
				if (worker_index !== seen_want.widx)
					note_mismatch($sformatf("worker_index got %0d want %0d",
						worker_index, seen_want.widx));
				if (job_id_out !== seen_want.id)
					note_mismatch($sformatf("job_id_out got %h want %h",
						job_id_out, seen_want.id));
				if (lines_left !== seen_want.left)
					note_mismatch($sformatf("lines_left got %h want %h",
						lines_left, seen_want.left));
				if (status !== seen_want.st)
					note_mismatch($sformatf("status got %0d want %0d", status, seen_want.st));
				if (last !== seen_want.lst)
					note_mismatch($sformatf("last got %b want %b", last, seen_want.lst));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

endmodule

[sim.f]
hw/rtl/fjd_pkg.sv
hw/rtl/fjd_queue.sv
hw/rtl/fjd_workers.sv
hw/rtl/fifo_job_dispatcher.sv
verif/fifo_job_dispatcher_tb.sv
